// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL, included by q_table_update_engine.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/qtu_pkg.sv -----
// Types and constants of the Q-table update engine.
// No dependencies.
package qtu_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned Q_W        = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_LEARNING_RATE = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DISCOUNT      = 4'd1;

  localparam logic [CFG_DATA_W-1:0] RATE_ONE          = 9'd256;
  localparam logic [CFG_DATA_W-1:0] LEARNING_RATE_RST = 9'd26;
  localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST      = 9'd230;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_UPDATE = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [3:0]            state_index;
    logic [1:0]            move;
    logic signed [Q_W-1:0] reward;
    logic [3:0]            next_state_index;
    logic signed [Q_W-1:0] load_value;
  } item_t;

  typedef struct packed {
    logic [1:0]            best_move;
    logic signed [Q_W-1:0] best_value;
    logic signed [Q_W-1:0] written_value;
  } result_t;

  // Step enables for the update arithmetic
  typedef struct packed {
    logic step_disc;  // discount * row maximum
    logic step_q;     // (1 - lr) * q, and target add
    logic step_tgt;   // lr * target
  } alu_ctrl_t;

endpackage

// ----- rtl/qtu_stream_if.sv -----
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; used with qtu_pkg item and result types.
interface qtu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/q_table_update_engine.sv -----
// Q-table update engine: sequencer, configuration registers and result register.
// Depends on qtu_pkg, qtu_stream_if, qtu_mem, qtu_update_alu, assert_macros.svh.
//
// The block holds a table of signed 16-bit Q values (NUM_STATES rows, one column
// per move) in a single-port-read synchronous memory and handles one item at a
// time. After reset a clearing pass writes zero to every entry, one a cycle,
// covering NUM_STATES * 2**clog2(NUM_ACTIONS) entries (64 at the defaults); no
// item beat is taken until it ends, though configuration writes are. Item cost,
// counted from the accepting edge to the result being offered, is set by the
// memory read port walking a row one column a cycle: select scans the current
// row; load writes the entry, then scans the row; update scans the next-state
// row, reads the entry alongside the discount multiply, runs two further
// multiply steps and the write-back, then scans the current row. The next item
// can be accepted in the cycle after a result is placed in the output register,
// even while that result waits for the sink. Row and move indexes are reduced
// modulo NUM_STATES and NUM_ACTIONS; rates above 256 are treated as 256.
module q_table_update_engine
  import qtu_pkg::*;
#(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_ACTIONS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  qtu_stream_if.sink            item,
  qtu_stream_if.source          result
);

`include "assert_macros.svh"

  localparam int unsigned RW    = $clog2(NUM_STATES);
  localparam int unsigned CW    = $clog2(NUM_ACTIONS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = NUM_STATES << CW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_WR,
    S_SCAN_NEXT,
    S_UPD_RDQ,
    S_UPD_MUL1,
    S_UPD_MUL2,
    S_UPD_WR,
    S_SCAN_ROW,
    S_RESULT
  } state_t;

  state_t state;

  // configuration, raw as written
  logic [CFG_DATA_W-1:0] lr_reg, disc_reg;

  // captured item
  logic [RW-1:0]         cur_row, nxt_row;
  logic [CW-1:0]         cur_col;
  logic signed [Q_W-1:0] reward, load_value;
  logic [CFG_DATA_W-1:0] lr, disc;

  // row scan
  logic [CW:0]           scan_cnt;
  logic                  rd_pend;
  logic [CW-1:0]         rd_col;
  logic signed [Q_W-1:0] best_val;
  logic [CW-1:0]         best_col;
  logic signed [Q_W-1:0] written;
  logic [AW-1:0]         clr_addr;

  // memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic signed [Q_W-1:0] mem_wdata, mem_rdata;

  logic                  scanning, rd_issue, scan_done;
  logic [RW-1:0]         scan_row;
  alu_ctrl_t             alu_ctrl;
  logic signed [Q_W-1:0] alu_result;
  logic [CW+1:0]         best_move_ext;

  // modulo tables for the fixed-width index fields
  logic [RW-1:0] row_map [16];
  logic [CW-1:0] col_map [4];

  for (genvar i = 0; i < 16; i++) begin : g_row_map
    assign row_map[i] = RW'(i % NUM_STATES);
  end
  for (genvar i = 0; i < 4; i++) begin : g_col_map
    assign col_map[i] = CW'(i % NUM_ACTIONS);
  end

  assign scanning  = (state == S_SCAN_NEXT) || (state == S_SCAN_ROW);
  assign rd_issue  = scanning && (scan_cnt != (CW+1)'(NUM_ACTIONS));
  assign scan_done = scanning && rd_pend && (rd_col == CW'(NUM_ACTIONS - 1));
  assign scan_row  = (state == S_SCAN_NEXT) ? nxt_row : cur_row;

  assign item.ready = (state == S_IDLE);

  // memory addressing: row in the upper bits, column in the lower
  always_comb begin
    mem_raddr = {scan_row, scan_cnt[CW-1:0]};
    if (state == S_UPD_RDQ) begin
      mem_raddr = {cur_row, cur_col};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_row, cur_col};
    mem_wdata = load_value;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_LOAD_WR: mem_we = 1'b1;
      S_UPD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = alu_result;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    alu_ctrl.step_disc = (state == S_UPD_RDQ);
    alu_ctrl.step_q    = (state == S_UPD_MUL1);
    alu_ctrl.step_tgt  = (state == S_UPD_MUL2);
  end

  qtu_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // q arrives from the memory during S_UPD_MUL1
  qtu_update_alu u_alu (
    .clk     (clk),
    .ctrl    (alu_ctrl),
    .lr      (lr),
    .disc    (disc),
    .row_max (best_val),
    .q       (mem_rdata),
    .reward  (reward),
    .result  (alu_result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lr_reg   <= LEARNING_RATE_RST;
      disc_reg <= DISCOUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LEARNING_RATE) begin
        lr_reg <= cfg_wdata;
      end else if (cfg_index == REG_DISCOUNT) begin
        disc_reg <= cfg_wdata;
      end
    end
  end

  // row scan: each read is compared in the cycle after it is issued; ties keep the lower column
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
    if (rd_issue) begin
      scan_cnt <= scan_cnt + 1'b1;
      rd_col   <= scan_cnt[CW-1:0];
    end else if (!scanning) begin
      scan_cnt <= '0;
    end
    if (scanning && rd_pend && ((rd_col == '0) || (mem_rdata > best_val))) begin
      best_val <= mem_rdata;
      best_col <= rd_col;
    end
  end

  assign best_move_ext = {2'b00, best_col};

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      result.valid <= 1'b0;
    end else begin
      // in S_RESULT the load below decides the valid bit
      if (result.valid && result.ready && (state != S_RESULT)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            cur_row    <= row_map[item.payload.state_index];
            nxt_row    <= row_map[item.payload.next_state_index];
            cur_col    <= col_map[item.payload.move];
            reward     <= item.payload.reward;
            load_value <= item.payload.load_value;
            lr         <= (lr_reg > RATE_ONE) ? RATE_ONE : lr_reg;
            disc       <= (disc_reg > RATE_ONE) ? RATE_ONE : disc_reg;
            written    <= '0;
            case (item.payload.action)
              ACT_LOAD:   state <= S_LOAD_WR;
              ACT_UPDATE: state <= S_SCAN_NEXT;
              default:    state <= S_SCAN_ROW;   // select, and the unused code
            endcase
          end
        end
        S_LOAD_WR: begin
          written <= load_value;
          state   <= S_SCAN_ROW;
        end
        S_SCAN_NEXT: begin
          if (scan_done) begin
            state <= S_UPD_RDQ;
          end
        end
        S_UPD_RDQ:  state <= S_UPD_MUL1;
        S_UPD_MUL1: state <= S_UPD_MUL2;
        S_UPD_MUL2: state <= S_UPD_WR;
        S_UPD_WR: begin
          written <= alu_result;
          state   <= S_SCAN_ROW;
        end
        S_SCAN_ROW: begin
          if (scan_done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!result.valid || result.ready) begin
            result.valid                 <= 1'b1;
            result.payload.best_move     <= best_move_ext[1:0];
            result.payload.best_value    <= best_val;
            result.payload.written_value <= written;
            state                        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an entry is never read in the cycle it is written
  `ASSERT_NEVER(a_no_rw_overlap, clk, rst, mem_we && rd_issue, "read during table write")
  // one beat per item: no second accept straight after the first
  `ASSERT_NEXT(a_single_accept, clk, rst, item.valid && item.ready, !item.ready, "double accept")
  // a finished result always reaches a free output register
  `ASSERT_NEXT(a_result_loaded, clk, rst,
    (state == S_RESULT) && (!result.valid || result.ready), result.valid, "result dropped")

endmodule

// ----- rtl/qtu_mem.sv -----
// Q-table storage: one write port, one read port, registered read data.
// Depends on qtu_pkg for the entry width.
module qtu_mem
  import qtu_pkg::*;
#(
  parameter int unsigned AW    = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic signed [Q_W-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic signed [Q_W-1:0] rdata
);

  logic signed [Q_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/qtu_update_alu.sv -----
// Multi-step arithmetic of the Q update: blend of old value and target.
// Depends on qtu_pkg (alu_ctrl_t, widths).
module qtu_update_alu
  import qtu_pkg::*;
(
  input  logic                   clk,
  input  alu_ctrl_t              ctrl,
  input  logic [CFG_DATA_W-1:0]  lr,       // clamped, 0..256
  input  logic [CFG_DATA_W-1:0]  disc,     // clamped, 0..256
  input  logic signed [Q_W-1:0]  row_max,
  input  logic signed [Q_W-1:0]  q,
  input  logic signed [Q_W-1:0]  reward,
  output logic signed [Q_W-1:0]  result
);

  logic signed [CFG_DATA_W:0] lr_s, disc_s, inv_lr_s;
  logic signed [25:0] disc_prod;
  logic signed [25:0] pq;
  logic signed [18:0] target;
  logic signed [28:0] pt;
  logic signed [29:0] sum;
  logic signed [21:0] scaled;

  assign lr_s     = $signed({1'b0, lr});
  assign disc_s   = $signed({1'b0, disc});
  assign inv_lr_s = $signed({1'b0, RATE_ONE}) - lr_s;

  always_ff @(posedge clk) begin
    if (ctrl.step_disc) begin
      disc_prod <= disc_s * row_max;
    end
    if (ctrl.step_q) begin
      pq     <= inv_lr_s * q;
      target <= 19'(reward) + 19'(disc_prod >>> 8);
    end
    if (ctrl.step_tgt) begin
      pt <= lr_s * target;
    end
  end

  // floor shift then clamp to 16 bits
  assign sum    = 30'(pq) + 30'(pt);
  assign scaled = 22'(sum >>> 8);

  always_comb begin
    if (scaled > 22'sd32767) begin
      result = 16'sh7fff;
    end else if (scaled < -22'sd32768) begin
      result = -16'sh8000;
    end else begin
      result = 16'(scaled);
    end
  end

endmodule
